[design/dsc_pkg.sv]
// shared types and constants for the displacement sensor conditioner
// no dependencies
`default_nettype none
package dsc_pkg;
	localparam int unsigned ZeroReset = 10000;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_CUTOFF  = 2'd1,
		ST_SPIKE   = 2'd2,
		ST_ZERO    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_CUTOFF_LEVEL = 3'd0,
		REG_CUTOFF_DIST  = 3'd1,
		REG_SURGE_THR    = 3'd2,
		REG_FRESET_THR   = 3'd3,
		REG_COEF_FB      = 3'd4,
		REG_COEF_CUR     = 3'd5,
		REG_COEF_PREV    = 3'd6,
		REG_GAIN         = 3'd7
	} reg_index_t;

	// request and reply between sequencer and serial units
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;
endpackage
`default_nettype wire

[design/dsc_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on dsc_pkg
`default_nettype none
module dsc_mul
	import dsc_pkg::*;
#(
	parameter int AW = 48,
	parameter int BW = 48
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire unit_req_t          req,
	input  wire logic [AW-1:0]      a,
	input  wire logic [BW-1:0]      b,
	output unit_rsp_t               rsp,
	output logic [AW+BW-1:0]        prod
);
	localparam int CW = $clog2(BW + 1);
	logic [CW-1:0] cnt_q;
	logic [AW+BW-1:0] acc_q, mc_q;
	logic [BW-1:0] mp_q;
	logic busy_q, done_q;

	// one partial product per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= {{BW{1'b0}}, a};
			mp_q  <= b;
		end else if (busy_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

[design/dsc_div.sv]
// restoring divider for unsigned values, one quotient bit per cycle
// depends on dsc_pkg
`default_nettype none
module dsc_div
	import dsc_pkg::*;
#(
	parameter int NW = 80,
	parameter int DW = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire unit_req_t     req,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output unit_rsp_t          rsp,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0] rs;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in next dividend bit and trial subtract
	assign rs = {r_q[DW-1:0], q_q[NW-1]};

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (rs >= {1'b0, d_q}) begin
				r_q <= rs - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quo = q_q;
endmodule
`default_nettype wire

[design/displacement_sensor_conditioner.sv]
// top level of the displacement sensor conditioner: sequencer and per-sensor state
// depends on dsc_pkg, dsc_mul, dsc_div
//
// usage
//  s_axis carries one word per item: a sample or a zero-point command for one sensor.
//  m_axis returns one word per item with the sensor number, distance, filter level
//  and status. a sensor number at or above SENSOR_COUNT is dropped with no result.
//  configuration registers are written through cfg_we/cfg_index/cfg_data while idle.
// sequencing
//  one item at a time: a new word is taken only once the result of the last one
//  has moved to the output register. zero-set, cut-off and spike words get their
//  result in the evaluation state. a filtered sample runs five serial products
//  (three for the filter sum, then numerator and denominator of the distance) and
//  then the serial divider. with zero gain, zero filter or zero zero point the
//  distance is fixed and the result comes after the three filter products.
// reset
//  arst_n clears all per-sensor state (zero point to 10000) and the registers
//  to their defaults, and empties the output register.
// stall
//  a finished result moves to the output register once that is free, so one more word
//  is taken and worked on while m_axis_tready is low; then s_axis_tready stays low.
`default_nettype none
module displacement_sensor_conditioner
	import dsc_pkg::*;
#(
	parameter int SENSOR_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [0] action, [3:1] sensor_id, [19:4] sample, [34:20] zero_value, rest zero
	input  wire logic [39:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] out_sensor, [34:3] distance, [58:35] filtered_level, [60:59] status
	output logic [63:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int SW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EVAL = 9'b000000010,
		S_M1   = 9'b000000100,
		S_M2   = 9'b000001000,
		S_M3   = 9'b000010000,
		S_DM1  = 9'b000100000,
		S_DM2  = 9'b001000000,
		S_DIV  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [14:0] cutoff_level_q;
	logic [31:0] cutoff_distance_q, gain_q;
	logic [15:0] surge_q, freset_q, cf_q, cc_q, cp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_level_q    <= '0;
			cutoff_distance_q <= '0;
			surge_q           <= 16'd100;
			freset_q          <= 16'd50;
			cf_q              <= 16'd13107;
			cc_q              <= 16'd1638;
			cp_q              <= 16'd1638;
			gain_q            <= 32'd1;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CUTOFF_LEVEL: cutoff_level_q    <= cfg_data[14:0];
				REG_CUTOFF_DIST:  cutoff_distance_q <= cfg_data;
				REG_SURGE_THR:    surge_q           <= cfg_data[15:0];
				REG_FRESET_THR:   freset_q          <= cfg_data[15:0];
				REG_COEF_FB:      cf_q              <= cfg_data[15:0];
				REG_COEF_CUR:     cc_q              <= cfg_data[15:0];
				REG_COEF_PREV:    cp_q              <= cfg_data[15:0];
				REG_GAIN:         gain_q            <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-sensor state
	logic signed [15:0] last_q [SENSOR_COUNT];
	logic signed [15:0] older_q [SENSOR_COUNT];
	logic signed [23:0] filt_q [SENSOR_COUNT];
	logic [14:0] zero_q [SENSOR_COUNT];
	logic signed [31:0] dist_q [SENSOR_COUNT];

	// captured item
	logic act_q;
	logic [SW-1:0] id_q;
	logic signed [15:0] smp_q, p_q, o_q;
	logic signed [23:0] f_q;
	logic [14:0] z_q, zv_q;
	logic th1_q;
	logic signed [47:0] acc_q;
	logic signed [23:0] nf_q;
	logic neg_q;
	logic [55:0] num_q;
	logic [63:0] res_q, out_q;
	logic out_v_q;
	logic load_out;

	// serial arithmetic units
	unit_req_t mreq, dreq;
	unit_rsp_t mrsp, drsp;
	logic [47:0] ma, mb;
	logic [95:0] mprod;
	logic [79:0] dnum, dquo;
	logic [39:0] dden;

	dsc_mul #(.AW(48), .BW(48)) u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .a(ma), .b(mb), .rsp(mrsp), .prod(mprod)
	);
	dsc_div #(.NW(80), .DW(40)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .num(dnum), .den(dden), .rsp(drsp), .quo(dquo)
	);

	logic [4:0] idx_chk;
	logic in_ok;
	assign idx_chk = {2'b0, s_axis_tdata[3:1]};
	assign in_ok = idx_chk < 5'(SENSOR_COUNT);
	assign s_axis_tready = (state_q == S_IDLE);

	// sample comparisons
	logic signed [17:0] d1, d2, ad1, ad2;
	logic th1, th2, cut;
	always_comb begin
		d1  = 18'(smp_q) - 18'(p_q);
		d2  = 18'(smp_q) - 18'(o_q);
		ad1 = d1[17] ? -d1 : d1;
		ad2 = d2[17] ? -d2 : d2;
		th1 = ad1 < $signed({2'b0, surge_q});
		th2 = ad2 < $signed({2'b0, surge_q});
		cut = smp_q < $signed({1'b0, cutoff_level_q});
	end

	// filter result: round, floor-shift, saturate, restart check
	logic signed [47:0] sum, rnd;
	logic signed [33:0] q34;
	logic signed [23:0] fsat, fnew;
	logic signed [24:0] lag, alag;
	logic signed [16:0] pair;
	always_comb begin
		sum  = acc_q + ($signed(mprod[47:0]) <<< 8);
		rnd  = sum + 48'sd8192;
		q34  = rnd[47:14];
		if (q34 > 34'sd8388607) fsat = 24'sh7fffff;
		else if (q34 < -34'sd8388608) fsat = -24'sh800000;
		else fsat = q34[23:0];
		lag  = 25'(fsat) - 25'({smp_q, 8'd0});
		alag = lag[24] ? -lag : lag;
		pair = 17'(smp_q) + 17'(th1_q ? p_q : o_q);
		if (alag > $signed({1'b0, freset_q, 8'd0})) fnew = {pair[16:0], 7'd0};
		else fnew = fsat;
	end

	// distance operands: |256*z - F| and |F|, fixed values for the corner cases
	logic signed [24:0] zdiff;
	logic [23:0] zdabs, fabs;
	logic dspecial;
	logic [31:0] dspec;
	always_comb begin
		zdiff = $signed({2'b00, z_q, 8'd0}) - 25'(fnew);
		zdabs = zdiff[24] ? 24'(-zdiff) : zdiff[23:0];
		fabs = nf_q[23] ? -nf_q : nf_q;
		dspecial = (gain_q == '0) || (fnew == '0) || (z_q == '0);
		dspec = (gain_q == '0) ? 32'd0 : (fnew == '0) ? 32'h7fffffff : 32'h80000000;
	end

	// multiplier operands; filter products are signed mod 2^48, distance ones unsigned
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_EVAL: begin
				ma = 48'(f_q);
				mb = 48'($signed(cf_q));
			end
			S_M1: begin
				ma = 48'(smp_q);
				mb = 48'($signed(cc_q));
			end
			S_M2: begin
				ma = 48'(p_q);
				mb = 48'($signed(cp_q));
			end
			S_M3: begin
				ma = {24'd0, zdabs};
				mb = {16'd0, gain_q};
			end
			S_DM1: begin
				ma = {24'd0, fabs};
				mb = {33'd0, z_q};
			end
			default: ;
		endcase
	end

	// distance: signed quotient from magnitude, saturated to 32 bits
	logic [31:0] dres;
	always_comb begin
		if (!neg_q) dres = (|dquo[79:31]) ? 32'h7fffffff : dquo[31:0];
		else dres = (|dquo[79:32] || (dquo[31:0] > 32'h80000000)) ? 32'h80000000
			: 32'd0 - dquo[31:0];
	end

	// unit start pulses
	always_comb begin
		mreq.start = 1'b0;
		dreq.start = 1'b0;
		unique case (state_q)
			S_EVAL: mreq.start = !act_q && !cut && (th1 || th2);
			S_M1, S_M2, S_DM1: mreq.start = mrsp.done;
			S_M3: mreq.start = mrsp.done && !dspecial;
			S_DM2: dreq.start = mrsp.done;
			default: ;
		endcase
	end

	assign dnum = {24'd0, num_q};
	assign dden = mprod[39:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				last_q[i]  <= '0;
				older_q[i] <= '0;
				filt_q[i]  <= '0;
				zero_q[i]  <= 15'(ZeroReset);
				dist_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready && in_ok) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (act_q) begin
						zero_q[id_q] <= zv_q;
						filt_q[id_q] <= 24'({zv_q, 8'd0});
						nf_q <= 24'({zv_q, 8'd0});
						res_q <= {3'd0, ST_ZERO, 24'({zv_q, 8'd0}), dist_q[id_q],
							3'(id_q)};
						state_q <= S_OUT;
					end else begin
						older_q[id_q] <= p_q;
						if (cut) begin
							last_q[id_q] <= $signed({1'b0, cutoff_level_q});
							filt_q[id_q] <= 24'({cutoff_level_q, 8'd0});
							dist_q[id_q] <= cutoff_distance_q;
							res_q <= {3'd0, ST_CUTOFF, 24'({cutoff_level_q, 8'd0}),
								cutoff_distance_q, 3'(id_q)};
							state_q <= S_OUT;
						end else begin
							last_q[id_q] <= smp_q;
							th1_q <= th1;
							if (!th1 && !th2) begin
								res_q <= {3'd0, ST_SPIKE, f_q, dist_q[id_q], 3'(id_q)};
								state_q <= S_OUT;
							end else begin
								acc_q <= '0;
								state_q <= S_M1;
							end
						end
					end
				end
				S_M1: if (mrsp.done) begin
					acc_q <= $signed(mprod[47:0]);
					state_q <= S_M2;
				end
				S_M2: if (mrsp.done) begin
					acc_q <= acc_q + ($signed(mprod[47:0]) <<< 8);
					state_q <= S_M3;
				end
				S_M3: if (mrsp.done) begin
					nf_q <= fnew;
					filt_q[id_q] <= fnew;
					neg_q <= zdiff[24] ^ fnew[23];
					if (dspecial) begin
						dist_q[id_q] <= dspec;
						res_q <= {3'd0, ST_UPDATED, fnew, dspec, 3'(id_q)};
						state_q <= S_OUT;
					end else begin
						state_q <= S_DM1;
					end
				end
				// numerator product done, denominator product starts
				S_DM1: if (mrsp.done) begin
					num_q <= mprod[55:0];
					state_q <= S_DM2;
				end
				S_DM2: if (mrsp.done) begin
					state_q <= S_DIV;
				end
				S_DIV: if (drsp.done) begin
					dist_q[id_q] <= dres;
					res_q <= {3'd0, ST_UPDATED, nf_q, dres, 3'(id_q)};
					state_q <= S_OUT;
				end
				S_OUT: if (load_out) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, loaded when empty or being drained
	assign load_out = (state_q == S_OUT) && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= res_q;
	end

	// capture the accepted word and its sensor state
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q <= s_axis_tdata[0];
			id_q  <= SW'(s_axis_tdata[3:1]);
			smp_q <= s_axis_tdata[19:4];
			zv_q  <= s_axis_tdata[34:20];
			p_q   <= last_q[SW'(s_axis_tdata[3:1])];
			o_q   <= older_q[SW'(s_axis_tdata[3:1])];
			f_q   <= filt_q[SW'(s_axis_tdata[3:1])];
			z_q   <= zero_q[SW'(s_axis_tdata[3:1])];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;
endmodule
`default_nettype wire

[tb/tb.sv]
// testbench for displacement_sensor_conditioner: random and directed words checked
// against a behavioral per-sensor filter predictor; depends on the dut and dsc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import dsc_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	// field order matches the output word, lowest bits last
	typedef struct packed {
		status_t     status;
		logic [23:0] level;
		logic [31:0] distance;
		logic [2:0]  sensor;
	} result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	displacement_sensor_conditioner dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [14:0] r_cut_level;
	logic [31:0] r_cut_dist;
	logic [15:0] r_surge, r_freset;
	logic signed [15:0] r_cf, r_cc, r_cp;
	logic [31:0] r_gain;
	longint sample_hist[8], older_hist[8], filt_q[8], dist_v[8];
	longint zero_pt[8];

	result_t expected_q[$];
	int  errors = 0;
	int  send_idle = 0, recv_idle = 0;
	bit  hold_off = 0;
	int  quiet_cycles = 0;

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint floor_div(longint a, longint d);
		if (a >= 0) return a / d;
		return -((-a + d - 1) / d);
	endfunction

	function automatic longint reciprocal_distance(longint f, longint z);
		longint num, den, q;
		if (r_gain == 0) return 0;
		if (f == 0) return 64'sd2147483647;
		if (z == 0) return -64'sd2147483648;
		num = (z * 256 - f) * longint'(r_gain);
		den = f * z;
		q = num / den;
		if (q > 64'sd2147483647) return 64'sd2147483647;
		if (q < -64'sd2147483648) return -64'sd2147483648;
		return q;
	endfunction

	task automatic reset_predictor();
		r_cut_level = 0; r_cut_dist = 0; r_surge = 100; r_freset = 50;
		r_cf = 13107; r_cc = 1638; r_cp = 1638; r_gain = 1;
		for (int i = 0; i < 8; i++) begin
			sample_hist[i] = 0; older_hist[i] = 0; filt_q[i] = 0;
			zero_pt[i] = ZeroReset; dist_v[i] = 0;
		end
	endtask

	// work out the result word of one item and update the sensor state
	task automatic predict_conditioning(bit action, int id, logic signed [15:0] smp,
			logic [14:0] zv);
		longint s, p, o, f, acc;
		bit th1, th2;
		status_t st;
		result_t r;
		if (action) begin
			zero_pt[id] = zv;
			filt_q[id] = longint'(zv) * 256;
			st = ST_ZERO;
		end else begin
			s = smp; p = sample_hist[id]; o = older_hist[id];
			if (s < longint'(r_cut_level)) begin
				s = r_cut_level;
				filt_q[id] = longint'(r_cut_level) * 256;
				dist_v[id] = longint'($signed(r_cut_dist));
				st = ST_CUTOFF;
			end else begin
				th1 = abs64(s - p) < longint'(r_surge);
				th2 = abs64(s - o) < longint'(r_surge);
				if (!th1 && !th2) begin
					st = ST_SPIKE;
				end else begin
					acc = filt_q[id] * longint'(r_cf)
						+ (s * longint'(r_cc) + p * longint'(r_cp)) * 256;
					f = floor_div(acc + 8192, 16384);
					if (f > 8388607) f = 8388607;
					if (f < -8388608) f = -8388608;
					if (abs64(f - s * 256) > longint'(r_freset) * 256)
						f = (s + (th1 ? p : o)) * 128;
					filt_q[id] = f;
					dist_v[id] = reciprocal_distance(f, zero_pt[id]);
					st = ST_UPDATED;
				end
			end
			older_hist[id] = p;
			sample_hist[id] = s;
		end
		r.sensor = id[2:0];
		r.distance = dist_v[id][31:0];
		r.level = filt_q[id][23:0];
		r.status = st;
		expected_q.push_back(r);
	endtask

	// send one word, honoring the sender idle rate; valid stays high after acceptance
	// and the caller drops it at the end of a burst
	task automatic send_word(bit action, int id, logic signed [15:0] smp, logic [14:0] zv);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		s_axis_tdata <= {5'b0, zv, smp, id[2:0], action};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (id < 8) predict_conditioning(action, id, smp, zv);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_CUTOFF_LEVEL: r_cut_level = val[14:0];
			REG_CUTOFF_DIST:  r_cut_dist = val;
			REG_SURGE_THR:    r_surge = val[15:0];
			REG_FRESET_THR:   r_freset = val[15:0];
			REG_COEF_FB:      r_cf = val[15:0];
			REG_COEF_CUR:     r_cc = val[15:0];
			REG_COEF_PREV:    r_cp = val[15:0];
			REG_GAIN:         r_gain = val;
		endcase
	endtask

	// wait for every expected word, then a margin for the block to settle
	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// receiver ready
	always @(posedge clk) begin
		if (hold_off) m_axis_tready <= 0;
		else m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// result checker
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[60:0];
			if (expected_q.size() == 0) begin
				$display("%0t unexpected word %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.sensor !== want.sensor || got.distance !== want.distance ||
						got.level !== want.level || got.status !== want.status) begin
					$display("%0t mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCH_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// random sample near the sensor's history so that the filter path dominates
	function automatic logic signed [15:0] near_sample(int id);
		longint v;
		v = sample_hist[id] + $signed($urandom_range(160)) - 80;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	task automatic test_directed();
		send_word(0, 0, 16'sh7fff, 15'd0);
		send_word(0, 0, 16'sh8000, 15'd0);
		send_word(0, 1, 16'sd0, 15'd0);
		send_word(0, 1, 16'sd10, 15'd0);
		send_word(0, 1, 16'sd500, 15'd0);
		send_word(1, 2, 16'sd0, 15'd1);
		send_word(1, 3, 16'sd0, 15'h7fff);
		send_word(0, 3, 16'sd30, 15'd0);
		send_word(0, 3, 16'sd40, 15'd0);
		send_word(1, 4, 16'sd0, 15'd0);
		send_word(0, 4, 16'sd1000, 15'd0);
		send_word(0, 5, 16'sd1, 15'd0);
		send_word(0, 7, 16'sd2, 15'h7fff);
		s_axis_tvalid <= 0;
		drain();
		write_reg(REG_CUTOFF_LEVEL, 32'd200);
		write_reg(REG_CUTOFF_DIST, 32'h8000_0000);
		write_reg(REG_GAIN, 32'd0);
		send_word(0, 6, 16'sd100, 15'd0);
		send_word(0, 6, 16'sd250, 15'd0);
		send_word(0, 6, 16'sd260, 15'd0);
		s_axis_tvalid <= 0;
		drain();
		write_reg(REG_GAIN, 32'hffff_ffff);
		write_reg(REG_CUTOFF_LEVEL, 32'd0);
		send_word(0, 6, 16'sd270, 15'd0);
		send_word(0, 0, 16'sd1, 15'd0);
		s_axis_tvalid <= 0;
		drain();
	endtask

	task automatic randomize_regs(bit extreme);
		write_reg(REG_CUTOFF_LEVEL, extreme ? 32'h7fff : $urandom_range(300));
		write_reg(REG_CUTOFF_DIST, $urandom);
		write_reg(REG_SURGE_THR, extreme ? 32'hffff : $urandom_range(400));
		write_reg(REG_FRESET_THR, extreme ? 32'd0 : $urandom_range(200));
		write_reg(REG_COEF_FB, extreme ? 32'h8000 : $urandom_range(16383));
		write_reg(REG_COEF_CUR, extreme ? 32'h7fff : $urandom_range(4000));
		write_reg(REG_COEF_PREV, extreme ? 32'h8000 : $urandom_range(4000));
		write_reg(REG_GAIN, extreme ? 32'hffff_ffff : $urandom);
	endtask

	task automatic test_random(int count);
		int id, k;
		logic [15:0] rs;
		logic [14:0] rz;
		for (int i = 0; i < count; i++) begin
			id = $urandom_range(7);
			k = $urandom_range(99);
			rs = 16'($urandom);
			rz = 15'($urandom);
			if (k < 5) send_word(1, id, rs, 15'($urandom_range(32767)));
			else if (k < 15) send_word(0, id, rs, rz);
			else send_word(0, id, near_sample(id), rz);
		end
		s_axis_tvalid <= 0;
	endtask

	task automatic test_back_pressure();
		fork
			begin
				hold_off = 1;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			test_random(20);
		join
		drain();
	endtask

	initial begin
		reset_predictor();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle = 20; recv_idle = 51;
		test_directed();
		test_back_pressure();
		randomize_regs(0);
		test_random(400);
		drain();
		send_idle = 51; recv_idle = 20;
		randomize_regs(1);
		test_random(150);
		drain();
		write_reg(REG_CUTOFF_LEVEL, 32'd0);
		write_reg(REG_SURGE_THR, 32'd100);
		write_reg(REG_FRESET_THR, 32'hffff);
		write_reg(REG_COEF_FB, 32'd13107);
		write_reg(REG_COEF_CUR, 32'd1638);
		write_reg(REG_COEF_PREV, 32'd1638);
		write_reg(REG_GAIN, 32'd1000);
		test_random(400);
		drain();
		send_idle = 0; recv_idle = 0;
		randomize_regs(0);
		test_random(550);
		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
